>>> rtl/nsrc_pkg.sv
`timescale 1ns / 1ps
// Package for the notch speed ramp controller: notch tables, decode helpers,
// controller states and the command/status structs between control and datapath.
// No dependencies.
package nsrc_pkg;

   // Default width of the wrapping tick counter.
   localparam int TICK_COUNTER_WIDTH_DEF = 8;

   // Field widths.
   localparam int NOTCH_W  = 5;
   localparam int LEVEL_W  = 4;
   localparam int SPEED_W  = 7;
   localparam int PERIOD_W = 5;
   localparam int BASE_W   = 4;
   localparam int PROD_W   = 11;

   // The divider dividend must hold a power-notch product (up to 680).
   localparam int PROD_MIN_W = 10;

   localparam logic [SPEED_W-1:0]  SPEED_CEILING   = 7'd85;
   localparam logic [SPEED_W-1:0]  EMERGENCY_DECEL = 7'd30;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX       = 4'd10;

   localparam logic signed [NOTCH_W-1:0] NOTCH_EMERGENCY = -5'sd9;
   localparam logic signed [NOTCH_W-1:0] NOTCH_POWER_TOP = 5'sd5;

   // What a tick does, decoded from the handle position.
   typedef enum logic [2:0] {
      KIND_HOLD,
      KIND_EMERGENCY,
      KIND_POWER,
      KIND_BRAKE,
      KIND_NEUTRAL
   } nsrc_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD_LOAD,
      ST_MOD_RUN,
      ST_DECIDE,
      ST_QUO_RUN,
      ST_COMMIT
   } nsrc_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request fields
      logic start_mod;  // load divider with tick counter and period
      logic decide;     // latch whether this tick's action is due
      logic start_quo;  // load divider with the power ramp product
      logic step;       // one divider iteration
      logic commit;     // update speed and counter, load the response
   } nsrc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_last;   // the divider is on its final iteration
      logic need_quo;   // a power ramp step needs a quotient
   } nsrc_status_type;

   function automatic nsrc_kind_type notch_kind(input logic signed [NOTCH_W-1:0] n);
      nsrc_kind_type k;
      if (n == NOTCH_EMERGENCY)
         k = KIND_EMERGENCY;
      else if (n < NOTCH_EMERGENCY || n > NOTCH_POWER_TOP)
         k = KIND_HOLD;
      else if (n > 5'sd0)
         k = KIND_POWER;
      else if (n < 5'sd0)
         k = KIND_BRAKE;
      else
         k = KIND_NEUTRAL;
      return k;
   endfunction

   // Power notch tables, indexed by notch minus one.
   function automatic logic [SPEED_W-1:0] pwr_max(input logic [2:0] k);
      logic [SPEED_W-1:0] v;
      case (k)
         3'd0:    v = 7'd20;
         3'd1:    v = 7'd45;
         3'd2:    v = 7'd65;
         3'd3:    v = 7'd75;
         default: v = 7'd85;
      endcase
      return v;
   endfunction

   function automatic logic [BASE_W-1:0] pwr_base(input logic [2:0] k);
      logic [BASE_W-1:0] v;
      case (k)
         3'd3:    v = 4'd5;
         3'd4:    v = 4'd8;
         default: v = 4'd4;
      endcase
      return v;
   endfunction

   function automatic logic [PERIOD_W-1:0] pwr_period(input logic [2:0] k);
      logic [PERIOD_W-1:0] v;
      case (k)
         3'd0:    v = 5'd5;
         3'd1:    v = 5'd3;
         3'd2:    v = 5'd2;
         default: v = 5'd1;
      endcase
      return v;
   endfunction

   // Brake notch tables, indexed by brake notch minus one.
   function automatic logic [PERIOD_W-1:0] brk_period(input logic [2:0] k);
      logic [PERIOD_W-1:0] v;
      case (k)
         3'd0:    v = 5'd4;
         3'd1:    v = 5'd3;
         3'd2:    v = 5'd2;
         default: v = 5'd1;
      endcase
      return v;
   endfunction

   function automatic logic [SPEED_W-1:0] brk_decel(input logic [2:0] k);
      logic [SPEED_W-1:0] v;
      case (k)
         3'd4:    v = 7'd2;
         3'd5:    v = 7'd5;
         3'd6:    v = 7'd9;
         3'd7:    v = 7'd15;
         default: v = 7'd1;
      endcase
      return v;
   endfunction

   // Drag period by level; level zero never acts, so its period is a dummy one.
   function automatic logic [PERIOD_W-1:0] drag_period(input logic [LEVEL_W-1:0] lvl);
      logic [PERIOD_W-1:0] v;
      case (lvl)
         4'd1:    v = 5'd30;
         4'd2:    v = 5'd25;
         4'd3:    v = 5'd20;
         4'd4:    v = 5'd16;
         4'd5:    v = 5'd13;
         4'd6:    v = 5'd10;
         4'd7:    v = 5'd8;
         4'd8:    v = 5'd6;
         4'd9:    v = 5'd4;
         4'd10:   v = 5'd2;
         default: v = 5'd1;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/nsrc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the notch speed ramp controller: request registers, speed and tick
// counter state, a shared bit-serial divider and the speed update. Uses nsrc_pkg.
module nsrc_datapath #(
   parameter int TICK_COUNTER_WIDTH = nsrc_pkg::TICK_COUNTER_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nsrc_pkg::nsrc_cmd_type              cmd,
   output nsrc_pkg::nsrc_status_type           status,
   input  logic signed [nsrc_pkg::NOTCH_W-1:0] req_handle_notch,
   input  logic [nsrc_pkg::LEVEL_W-1:0]        req_resistance_level,
   output logic [nsrc_pkg::SPEED_W-1:0]        rsp_speed
);
   import nsrc_pkg::*;

   localparam int DW = (TICK_COUNTER_WIDTH > PROD_MIN_W) ? TICK_COUNTER_WIDTH : PROD_MIN_W;
   localparam int CW = $clog2(DW + 1);

   // Request, state and divider registers.
   logic signed [NOTCH_W-1:0] notch_ff;
   logic [LEVEL_W-1:0]        level_ff;
   logic [SPEED_W-1:0]        speed_ff, speed_in;
   logic [TICK_COUNTER_WIDTH-1:0] tick_ff, tick_in;
   logic [SPEED_W-1:0]        rsp_speed_ff;
   logic                      hit_ff;
   logic [DW-1:0]             dvd_ff, dvd_in;
   logic [SPEED_W-1:0]        rem_ff, rem_in;
   logic [SPEED_W-1:0]        dsr_ff, dsr_in;
   logic [CW-1:0]             cnt_ff, cnt_in;

   // Decode of the held request.
   nsrc_kind_type        kind;
   logic [2:0]           pidx, bidx;
   logic [LEVEL_W-1:0]   level_c;
   logic [PERIOD_W-1:0]  period;
   logic [SPEED_W-1:0]   mx;
   logic                 rises;
   logic [SPEED_W-1:0]   absd;
   logic [PROD_W-1:0]    prod;
   logic [SPEED_W:0]     trial;
   logic                 ge;
   logic [SPEED_W-1:0]   step_amt;
   logic [SPEED_W:0]     sum;

   always_comb begin
      kind    = notch_kind(notch_ff);
      pidx    = 3'(notch_ff - 5'sd1);
      bidx    = 3'(~notch_ff);
      level_c = (level_ff > LEVEL_MAX) ? LEVEL_MAX : level_ff;
      case (kind)
         KIND_POWER:   period = pwr_period(pidx);
         KIND_BRAKE:   period = brk_period(bidx);
         KIND_NEUTRAL: period = drag_period(level_c);
         default:      period = 5'd1;
      endcase
      mx    = pwr_max(pidx);
      rises = (mx > speed_ff);
      absd  = rises ? (mx - speed_ff) : (speed_ff - mx);
      prod  = PROD_W'(pwr_base(pidx)) * PROD_W'(absd);
   end

   // One restoring division step: remainder stays below the divisor.
   always_comb begin
      trial = {rem_ff, dvd_ff[DW-1]};
      ge    = (trial >= {1'b0, dsr_ff});
   end

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (cmd.start_mod) begin
         dvd_in = DW'(tick_ff);
         rem_in = '0;
         dsr_in = SPEED_W'(period);
         cnt_in = CW'(DW);
      end else if (cmd.start_quo) begin
         dvd_in = DW'(prod);
         rem_in = '0;
         dsr_in = rises ? mx : speed_ff;
         cnt_in = CW'(DW);
      end else if (cmd.step && cnt_ff != '0) begin
         dvd_in = {dvd_ff[DW-2:0], ge};
         rem_in = ge ? 7'(trial - {1'b0, dsr_ff}) : trial[SPEED_W-1:0];
         cnt_in = cnt_ff - CW'(1);
      end
   end

   // Status to the controller; the remainder is valid in the decision state.
   assign status.div_last = (cnt_ff == CW'(1));
   assign status.need_quo = (kind == KIND_POWER) && (rem_ff == '0) && (speed_ff != mx);

   // Speed update. The ramp amount is at least one.
   always_comb begin
      step_amt = (dvd_ff[SPEED_W-1:0] == '0) ? 7'd1 : dvd_ff[SPEED_W-1:0];
      sum      = {1'b0, speed_ff} + {1'b0, step_amt};
      speed_in = speed_ff;
      tick_in  = tick_ff + TICK_COUNTER_WIDTH'(1);
      case (kind)
         KIND_HOLD: begin
            tick_in = tick_ff;
         end
         KIND_EMERGENCY: begin
            tick_in  = tick_ff;
            speed_in = (speed_ff >= EMERGENCY_DECEL) ? speed_ff - EMERGENCY_DECEL : '0;
         end
         KIND_POWER: begin
            if (hit_ff && speed_ff != mx) begin
               if (rises)
                  speed_in = (sum > {1'b0, SPEED_CEILING}) ? SPEED_CEILING : sum[SPEED_W-1:0];
               else
                  speed_in = (speed_ff >= step_amt) ? speed_ff - step_amt : '0;
            end
         end
         KIND_BRAKE: begin
            if (hit_ff)
               speed_in = (speed_ff >= brk_decel(bidx)) ? speed_ff - brk_decel(bidx) : '0;
         end
         default: begin
            if (hit_ff && level_c != '0 && speed_ff != '0)
               speed_in = speed_ff - 7'd1;
         end
      endcase
   end

   // Control state: speed, tick counter and divider step count.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         tick_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.commit) begin
            speed_ff <= speed_in;
            tick_ff  <= tick_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (cmd.load) begin
         notch_ff <= req_handle_notch;
         level_ff <= req_resistance_level;
      end
      if (cmd.decide)
         hit_ff <= (rem_ff == '0);
      if (cmd.commit)
         rsp_speed_ff <= speed_in;
   end

   assign rsp_speed = rsp_speed_ff;

endmodule

>>> rtl/nsrc_ctrl.sv
`timescale 1ns / 1ps
// Controller of the notch speed ramp controller: sequences the divider runs
// and owns the request and response handshakes. Uses nsrc_pkg.
module nsrc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output nsrc_pkg::nsrc_cmd_type    cmd,
   input  nsrc_pkg::nsrc_status_type status
);
   import nsrc_pkg::*;

   nsrc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // State and response-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD_LOAD;
            end
         end
         ST_MOD_LOAD: begin
            cmd.start_mod = 1'b1;
            state_in      = ST_MOD_RUN;
         end
         ST_MOD_RUN: begin
            cmd.step = 1'b1;
            if (status.div_last)
               state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.need_quo) begin
               cmd.start_quo = 1'b1;
               state_in      = ST_QUO_RUN;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_QUO_RUN: begin
            cmd.step = 1'b1;
            if (status.div_last)
               state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/notch_speed_ramp_controller_unit.sv
`timescale 1ns / 1ps
// Notch speed ramp controller, top level. Uses nsrc_pkg, nsrc_ctrl, nsrc_datapath.
// The shared divider works one bit per cycle over DW = max(TICK_COUNTER_WIDTH, 10)
// bits: one run for the tick modulo, and a second run for the quotient on a power
// ramp step. A new request is taken only once the last response is loaded, and
// loading waits while an earlier response is still waiting.
// Reset clears speed, tick counter, controller state and the response valid.
module notch_speed_ramp_controller_unit #(
   parameter int TICK_COUNTER_WIDTH = nsrc_pkg::TICK_COUNTER_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [nsrc_pkg::NOTCH_W-1:0] req_handle_notch,
   input  logic [nsrc_pkg::LEVEL_W-1:0]        req_resistance_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [nsrc_pkg::SPEED_W-1:0]        rsp_speed
);
   import nsrc_pkg::*;

   nsrc_cmd_type    cmd;
   nsrc_status_type status;

   // Sequencer.
   nsrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and state.
   nsrc_datapath #(
      .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_handle_notch     (req_handle_notch),
      .req_resistance_level (req_resistance_level),
      .rsp_speed            (rsp_speed)
   );

endmodule

>>> tb/nsrc_speed_checker.sv
`timescale 1ns / 1ps
// Speed checker for the notch speed ramp controller: watches the request and
// response channels, predicts each speed and compares it. Depends on nsrc_pkg.
module nsrc_speed_checker #(
   parameter int TICK_COUNTER_WIDTH = nsrc_pkg::TICK_COUNTER_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [nsrc_pkg::NOTCH_W-1:0] req_handle_notch,
   input  logic [nsrc_pkg::LEVEL_W-1:0]        req_resistance_level,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [nsrc_pkg::SPEED_W-1:0]        rsp_speed,
   output int                                  fail_count = 0,
   output int                                  outstanding = 0
);
   import nsrc_pkg::*;

   // Notch and drag tables, indexed by notch minus one, brake notch minus one or drag level.
   int ramp_top    [5]  = '{20, 45, 65, 75, 85};
   int ramp_gain   [5]  = '{4, 4, 4, 5, 8};
   int ramp_every  [5]  = '{5, 3, 2, 1, 1};
   int brake_every [8]  = '{4, 3, 2, 1, 1, 1, 1, 1};
   int brake_drop  [8]  = '{1, 1, 1, 1, 2, 5, 9, 15};
   int drag_every  [11] = '{1, 30, 25, 20, 16, 13, 10, 8, 6, 4, 2};

   // Predicted state of the controller.
   logic [SPEED_W-1:0]            speed_now = '0;
   logic [TICK_COUNTER_WIDTH-1:0] tick_now  = '0;

   // Speeds predicted for requests whose response has not yet arrived.
   logic [SPEED_W-1:0] speeds_due [$];
   logic [SPEED_W-1:0] speed_wanted;
   int                 mismatches = 0;

   // Applies one tick to the predicted state.
   task automatic advance_ramp(input logic signed [NOTCH_W-1:0] notch,
                               input logic [LEVEL_W-1:0] level_in);
      nsrc_kind_type kind;
      int            spd;
      int            tc;
      int            n;
      int            k;
      int            lvl;
      int            shortfall;
      int            delta;
      spd = int'(speed_now);
      tc  = int'(tick_now);
      n   = int'(notch);
      lvl = (level_in > LEVEL_MAX) ? int'(LEVEL_MAX) : int'(level_in);

      if (notch == NOTCH_EMERGENCY)
         kind = KIND_EMERGENCY;
      else if (notch < NOTCH_EMERGENCY || notch > NOTCH_POWER_TOP)
         kind = KIND_HOLD;
      else if (n > 0)
         kind = KIND_POWER;
      else if (n < 0)
         kind = KIND_BRAKE;
      else
         kind = KIND_NEUTRAL;

      case (kind)
         KIND_EMERGENCY: begin
            // The counter stays where it is on an emergency tick.
            spd = spd - int'(EMERGENCY_DECEL);
            if (spd < 0)
               spd = 0;
            speed_now = SPEED_W'(spd);
         end
         KIND_HOLD: begin
            // Nothing changes on a hold tick.
         end
         default: begin
            if (kind == KIND_POWER) begin
               k = n - 1;
               if (tc % ramp_every[k] == 0) begin
                  shortfall = ramp_top[k] - spd;
                  if (shortfall > 0) begin
                     delta = (ramp_gain[k] * shortfall) / ramp_top[k];
                     spd = spd + ((delta < 1) ? 1 : delta);
                  end else if (shortfall < 0 && spd > 0) begin
                     delta = (ramp_gain[k] * (-shortfall)) / spd;
                     spd = spd - ((delta < 1) ? 1 : delta);
                  end
               end
            end else if (kind == KIND_BRAKE) begin
               k = -n - 1;
               if (tc % brake_every[k] == 0)
                  spd = spd - brake_drop[k];
            end else if (lvl > 0) begin
               if (tc % drag_every[lvl] == 0)
                  spd = spd - 1;
            end
            if (spd < 0)
               spd = 0;
            if (spd > int'(SPEED_CEILING))
               spd = int'(SPEED_CEILING);
            speed_now = SPEED_W'(spd);
            tick_now  = TICK_COUNTER_WIDTH'(tc + 1);
         end
      endcase
   endtask

   // Compare responses first, then predict for a request taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         speed_now = '0;
         tick_now  = '0;
         speeds_due.delete();
         mismatches = 0;
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (speeds_due.size() == 0) begin
               mismatches++;
               $display("%0t: speed response with no request waiting: expected none, actual %0d",
                        $time, rsp_speed);
            end else begin
               speed_wanted = speeds_due.pop_front();
               if (rsp_speed !== speed_wanted) begin
                  mismatches++;
                  $display("%0t: speed mismatch: expected %0d, actual %0d",
                           $time, speed_wanted, rsp_speed);
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_ramp(req_handle_notch, req_resistance_level);
            speeds_due.push_back(speed_now);
         end
         fail_count  <= mismatches;
         outstanding <= speeds_due.size();
      end
   end

endmodule

>>> tb/notch_speed_ramp_controller_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the notch speed ramp controller: clock, reset, request
// stimulus, response back-pressure and the verdict. Depends on nsrc_pkg and nsrc_speed_checker.
module notch_speed_ramp_controller_unit_tb;
   import nsrc_pkg::*;

   localparam int RANDOM_TICKS = 850;
   localparam int DRAIN_CYCLES = 40;

   logic                        clock;
   logic                        reset                = 1'b1;
   logic                        req_valid            = 1'b0;
   logic                        req_ready;
   logic signed [NOTCH_W-1:0]   req_handle_notch     = '0;
   logic [LEVEL_W-1:0]          req_resistance_level = '0;
   logic                        rsp_valid;
   logic                        rsp_ready            = 1'b0;
   logic [SPEED_W-1:0]          rsp_speed;
   int                          fail_count;
   int                          outstanding;

   // While set, neither side idles.
   bit calm = 1'b0;
   int hold_off = 0;

   // Directed ticks: emergency at rest, a climb on the top notch, the lowest
   // notch above its maximum, holds at both ends, brakes and drag levels.
   int directed_notch [25] = '{0, -9, 5, 5, 5, 5, 5, 5, 1, 1, 1, 1, -16, 15, 6, -10,
                               -8, -1, -4, 0, 0, 2, 3, -9, 0};
   int directed_level [25] = '{0, 0, 3, 0, 15, 0, 10, 0, 0, 0, 0, 0, 0, 7, 0, 0,
                               0, 0, 11, 10, 15, 0, 4, 0, 10};

   notch_speed_ramp_controller_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_handle_notch     (req_handle_notch),
      .req_resistance_level (req_resistance_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_speed            (rsp_speed)
   );

   nsrc_speed_checker speed_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_handle_notch     (req_handle_notch),
      .req_resistance_level (req_resistance_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_speed            (rsp_speed),
      .fail_count           (fail_count),
      .outstanding          (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // Offers one request and waits until it is taken.
   task automatic send_tick(input logic signed [NOTCH_W-1:0] notch,
                            input logic [LEVEL_W-1:0] level);
      int gap;
      gap = calm ? 0 : idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_handle_notch     <= notch;
      req_resistance_level <= level;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // A handle position outside the defined range.
   function automatic logic signed [NOTCH_W-1:0] hold_notch();
      int v;
      if ($urandom_range(0, 1))
         v = $urandom_range(6, 15);
      else
         v = -int'($urandom_range(10, 16));
      return NOTCH_W'(v);
   endfunction

   // Response back-pressure.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            hold_off--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               hold_off = idle_span();
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int                        counted;
      int                        seg;
      int                        run;
      int                        seg_level;
      logic signed [NOTCH_W-1:0] seg_notch;
      logic signed [NOTCH_W-1:0] notch;
      logic [LEVEL_W-1:0]        level;
      counted = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 25; i++)
         send_tick(NOTCH_W'(directed_notch[i]), LEVEL_W'(directed_level[i]));

      // Random segments: the handle mostly rests on one position for a while,
      // so the speed ramps all the way up and down; holds and noise in between.
      while (counted < RANDOM_TICKS) begin
         seg       = $urandom_range(0, 99);
         seg_level = $urandom_range(0, 10);
         calm      = ($urandom_range(0, 7) == 0);
         if (seg < 45) begin
            seg_notch = NOTCH_W'($urandom_range(1, 5));
            run       = $urandom_range(5, 60);
         end else if (seg < 70) begin
            seg_notch = NOTCH_W'(-int'($urandom_range(1, 8)));
            run       = $urandom_range(1, 15);
         end else if (seg < 85) begin
            seg_notch = '0;
            run       = $urandom_range(5, 60);
         end else if (seg < 90) begin
            seg_notch = NOTCH_EMERGENCY;
            run       = $urandom_range(1, 3);
         end else begin
            seg_notch = '0;
            run       = $urandom_range(1, 8);
         end
         for (int i = 0; i < run; i++) begin
            if (seg >= 95)
               notch = NOTCH_W'($urandom_range(0, 31));
            else if (seg >= 90)
               notch = hold_notch();
            else
               notch = seg_notch;
            level = ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom_range(0, 15))
                                                : LEVEL_W'(seg_level);
            send_tick(notch, level);
            if (notch >= NOTCH_EMERGENCY && notch <= NOTCH_POWER_TOP)
               counted++;
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // Let every expected speed arrive, then watch for strays.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("notch_speed_ramp_controller_unit regression: pass");
      else
         $display("notch_speed_ramp_controller_unit regression: fail");
      $finish;
   end

   // Run limit.
   initial begin
      #3000000;
      $display("notch_speed_ramp_controller_unit regression: fail");
      $finish;
   end

endmodule

>>> files.f
rtl/nsrc_pkg.sv
rtl/nsrc_datapath.sv
rtl/nsrc_ctrl.sv
rtl/notch_speed_ramp_controller_unit.sv
tb/nsrc_speed_checker.sv
tb/notch_speed_ramp_controller_unit_tb.sv
